### src/mft_pkg.sv
// Shared types and constants for the missed frame tracker.
package mft_pkg;

  localparam int unsigned FRAME_W = 16;
  localparam int unsigned COUNT_W = 6;

  localparam logic [FRAME_W-1:0] EMPTY_MARK = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } back_state_e;

endpackage

### src/mft_front.sv
// Input side: accept words, classify them and queue them for the table engine.
module mft_front
  import mft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_action_i,
  input  logic [FRAME_W-1:0] in_frame_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  cmd_t       cmd_new;

  // Reserved empty mark never touches the table.
  always_comb begin
    cmd_new.frame = in_frame_i;
    if (in_frame_i == EMPTY_MARK) begin
      cmd_new.op = OP_NOP;
    end else if (in_action_i) begin
      cmd_new.op = OP_DELETE;
    end else begin
      cmd_new.op = OP_INSERT;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### src/mft_back.sv
// Table engine: scan the slot memory, apply insert or delete, report the count.
module mft_back
  import mft_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] out_count_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic [FRAME_W-1:0]    mem [SLOT_COUNT];
  logic [FRAME_W-1:0]    rd_data_q;
  logic [SLOT_COUNT-1:0] used_q;

  back_state_e        state_q, state_d;
  logic [IDX_W-1:0]   idx_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               found_q;
  logic [IDX_W-1:0]   found_idx_q;
  logic               free_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [CNT_W-1:0]   count_q;
  logic               out_vld_q;
  logic [COUNT_W-1:0] out_cnt_q;

  logic start, rd_en, do_insert, do_delete, load_out;
  logic hit, empty_slot;
  logic [EXT_W-1:0]   count_ext;
  logic [COUNT_W-1:0] count_sat;

  assign hit        = cmp_vld_q && used_q[cmp_idx_q] && (rd_data_q == cmd_i.frame);
  assign empty_slot = cmp_vld_q && !used_q[cmp_idx_q];

  assign count_ext = EXT_W'(count_q);
  assign count_sat = (count_ext > EXT_W'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_NOP) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    start       = 1'b0;
    rd_en       = 1'b0;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    load_out    = 1'b0;
    cmd_ready_o = 1'b0;
    case (state_q)
      ST_IDLE:   start = cmd_valid_i;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: begin
        do_insert = (cmd_i.op == OP_INSERT) && !found_q && free_q;
        do_delete = (cmd_i.op == OP_DELETE) && found_q;
      end
      ST_RESULT: begin
        load_out    = !out_vld_q || out_ready_i;
        cmd_ready_o = load_out;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      used_q      <= '0;
      count_q     <= '0;
      out_vld_q   <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en;
      cmp_idx_q <= idx_q;
      if (start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (rd_en) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      // Keep the first matching slot and the lowest free slot.
      if (hit && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= cmp_idx_q;
      end
      if (empty_slot && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
      if (do_insert) begin
        used_q[free_idx_q] <= 1'b1;
        count_q            <= count_q + CNT_W'(1);
      end else if (do_delete) begin
        used_q[found_idx_q] <= 1'b0;
        count_q             <= count_q - CNT_W'(1);
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
        out_cnt_q <= count_sat;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      mem[free_idx_q] <= cmd_i.frame;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_count_o = out_cnt_q;

endmodule

### src/missed_frame_tracker_core.sv
// Top level of the missed frame tracker: input queue plus table engine.
//
//  channel   direction  tdata                      tuser
//  s_axis    in         [15:0] frame_number        [0] action (0 insert, 1 delete)
//  m_axis    out        [5:0] missing_count        -
//
// Each word runs through the table engine as a scan of the slot memory (one slot
// read per cycle), then the drain, commit and result states; frame 65535 skips to result.
// Reset marks every slot empty through its flip-flop used bit, no sweep needed.
// A two-word queue keeps s_axis open while the engine works; the engine holds
// its result when m_axis stalls and retires no new word until it is sent.
module missed_frame_tracker_core
  import mft_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] frame_number
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [5:0] missing_count, [7:6] zero
);

  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;
  logic [COUNT_W-1:0] out_count;

  mft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_frame_i  (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mft_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_count_o (out_count)
  );

  assign m_axis_tdata_o = {2'b00, out_count};

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[5:0]) <= SLOT_COUNT))
    else $error("missing count above table size");

  a_pop_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> m_axis_tvalid_o)
    else $error("command retired without a result word");

  a_pop_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten while stalled");

endmodule

### dv/mft_count_checker.sv
// Checker for the missed frame tracker: tracks the slot table and checks every count word.
module mft_count_checker
  import mft_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] frame_number
  input  logic        s_axis_tuser_i,   // [0] action
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [5:0] missing_count, [7:6] zero
  output int          failures_o,
  output int          pending_o
);

  logic [FRAME_W-1:0] slot_frame [SLOT_COUNT];
  logic               slot_used  [SLOT_COUNT];
  logic [COUNT_W-1:0] count_expected_q [$];
  logic [COUNT_W-1:0] count_expected;
  int                 failures = 0;

  assign failures_o = failures;

  task automatic report_mismatch(input string msg);
    $display("%0t mft_count_checker: %s", $time, msg);
    failures++;
  endtask

  // Apply one insert or delete to the table and return the occupied count after it.
  function automatic logic [COUNT_W-1:0] table_update(input logic act,
                                                     input logic [FRAME_W-1:0] num);
    int hit;
    int free;
    int occupied;
    hit      = -1;
    free     = -1;
    occupied = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_used[i] && slot_frame[i] == num && hit < 0) hit = i;
      if (!slot_used[i] && free < 0) free = i;
    end
    // the empty mark itself never enters or leaves the table
    if (num != EMPTY_MARK) begin
      if (act == 1'(OP_DELETE)) begin
        if (hit >= 0) begin
          slot_used[hit]  = 1'b0;
          slot_frame[hit] = EMPTY_MARK;
        end
      end else if (hit < 0 && free >= 0) begin
        slot_used[free]  = 1'b1;
        slot_frame[free] = num;
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_used[i]) occupied++;
    end
    if (occupied > COUNT_MAX) occupied = COUNT_MAX;
    return COUNT_W'(occupied);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i]  = 1'b0;
        slot_frame[i] = EMPTY_MARK;
      end
      count_expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (count_expected_q.size() == 0) begin
          report_mismatch($sformatf("count word 0x%02h with no input word pending",
                                    m_axis_tdata_i));
        end else begin
          count_expected = count_expected_q.pop_front();
          if (m_axis_tdata_i[5:0] != count_expected) begin
            report_mismatch($sformatf("missing_count %0d, expected %0d",
                                      m_axis_tdata_i[5:0], count_expected));
          end
          if (m_axis_tdata_i[7:6] != 2'b00) begin
            report_mismatch($sformatf("pad bits 0x%0h, expected zero", m_axis_tdata_i[7:6]));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        count_expected_q.push_back(table_update(s_axis_tuser_i, s_axis_tdata_i));
      end
    end
    pending_o = count_expected_q.size();
  end

endmodule

### dv/tb_missed_frame_tracker_core.sv
// Testbench top for the missed frame tracker: stimulus, flow control, watchdog and verdict.
module tb_missed_frame_tracker_core
  import mft_pkg::*;
;

  localparam int unsigned SLOT_COUNT   = 50;
  localparam int unsigned POOL_SIZE    = 72;
  localparam int unsigned ROUND_LEN    = 280;
  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned CALM_FIRST   = 600;
  localparam int unsigned CALM_LAST    = 800;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * (SLOT_COUNT + 4);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int          failures;
  int          pending;
  int          words_in = 0;
  int          words_out = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          held = 1'b0;
  logic [15:0] frame_pool [POOL_SIZE];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  missed_frame_tracker_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  mft_count_checker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .failures_o      (failures),
    .pending_o       (pending)
  );

  // Offer one word after a random idle gap and hold it until the block takes it.
  task automatic offer_word(input logic act, input logic [15:0] num);
    calm = (words_in >= CALM_FIRST && words_in < CALM_LAST);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= num;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_in++;
  endtask

  initial begin
    int unsigned roll;
    int unsigned ins_pct;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, duplicates, the empty mark, absent deletes, lowest-slot reuse
    offer_word(1'(OP_INSERT), 16'h0000);
    offer_word(1'(OP_INSERT), 16'hFFFE);
    offer_word(1'(OP_INSERT), 16'h0000);
    offer_word(1'(OP_INSERT), EMPTY_MARK);
    offer_word(1'(OP_DELETE), EMPTY_MARK);
    offer_word(1'(OP_DELETE), 16'h1234);
    offer_word(1'(OP_INSERT), 16'h5555);
    offer_word(1'(OP_INSERT), 16'hAAAA);
    offer_word(1'(OP_DELETE), 16'h0000);
    offer_word(1'(OP_INSERT), 16'h7FFF);
    offer_word(1'(OP_DELETE), 16'hFFFE);
    offer_word(1'(OP_DELETE), 16'h5555);
    offer_word(1'(OP_DELETE), 16'h7FFF);
    offer_word(1'(OP_DELETE), 16'hAAAA);
    offer_word(1'(OP_DELETE), 16'hAAAA);
    offer_word(1'(OP_INSERT), 16'h8000);

    for (int k = 0; k < POOL_SIZE; k++) frame_pool[k] = 16'($urandom_range(16'hFFFE));
    frame_pool[0] = 16'h0000;
    frame_pool[1] = 16'hFFFE;

    // each round: fill past capacity, churn, then sweep the pool out
    repeat (3) begin
      for (int k = 0; k < ROUND_LEN; k++) begin
        ins_pct = (k < ROUND_LEN / 2) ? 85 : 50;
        roll = $urandom_range(99);
        if (roll < 3) begin
          offer_word(1'($urandom_range(1)), EMPTY_MARK);
        end else if (roll < 6) begin
          offer_word(1'(OP_DELETE), 16'($urandom));
        end else if (roll < 7) begin
          offer_word(1'(OP_INSERT), 16'($urandom_range(16'hFFFE)));
        end else begin
          offer_word(($urandom_range(99) < ins_pct) ? 1'(OP_INSERT) : 1'(OP_DELETE),
                     frame_pool[$urandom_range(POOL_SIZE - 1)]);
        end
      end
      for (int k = 0; k < POOL_SIZE; k++) begin
        offer_word(1'(OP_DELETE), frame_pool[k]);
        frame_pool[k] = 16'($urandom_range(16'hFFFE));
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the checker log the last word before looking at the pending count
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_missed_frame_tracker_core: clean");
    end else begin
      $display("tb_missed_frame_tracker_core: errors");
    end
    $finish;
  end

  // Receiver: random backpressure, one long hold-off so the input side fills and stalls.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) words_out++;
      if (!held && words_out >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_missed_frame_tracker_core: errors");
        $finish;
      end
    end
  end

endmodule
